// ----- rtl/ism_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ism_pkg
// Types and helpers shared by the interval sort-and-merge block.
// ----------------------------------------------------------------------------
package ism_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned SPAN_W = 2 * POS_W;

    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_span;

    // Closed intervals overlap when they share at least one position.
    function automatic logic spans_touch(input t_span a, input t_span b);
        return (a.lo <= b.hi) && (b.lo <= a.hi);
    endfunction

    function automatic t_span span_union(input t_span a, input t_span b);
        t_span u;
        u.lo = (b.lo < a.lo) ? b.lo : a.lo;
        u.hi = (b.hi > a.hi) ? b.hi : a.hi;
        return u;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ism_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ism_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// Read data holds when no read is enabled.
// ----------------------------------------------------------------------------
module ism_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/interval_sort_and_merge.sv -----
`default_nettype none
// Load: one transfer per cycle; the input is stalled outside the load state. After the last item
// the batch of n stored intervals is selection-sorted in place through one RAM read port: each
// pass scans the unsorted tail for the smallest start, then swaps it into place if it is not there.
// The merge walk then reads and checks each stored interval in turn, held by output stalls, then flushes.
// Batches: one at a time; a new batch is not accepted until the last one has been flushed.
// Reset: control state, count and overflow flag clear; the store is not cleared.
// ----------------------------------------------------------------------------
// interval_sort_and_merge
// Collects closed intervals, sorts them by start, merges overlapping neighbors
// and emits the merged intervals in order, flagging the final one.
// ----------------------------------------------------------------------------
module interval_sort_and_merge #(
    parameter int unsigned MAX_INTERVALS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_interval_start,
    input  wire logic [31:0] i_interval_end,
    input  wire logic        i_batch_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_merged_start,
    output logic [31:0]      o_merged_end,
    output logic             o_run_last,
    output logic             o_overflow
);

    import ism_pkg::*;

    localparam int unsigned AW = $clog2(MAX_INTERVALS);
    localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_SCAN_END,
        S_SWAP1,
        S_SWAP2,
        S_MRD,
        S_MCHK,
        S_FLUSH
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_r, n_r;
    logic          r_rd_vld, n_rd_vld;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    t_span         r_first, n_first;
    t_span         r_best, n_best;
    logic [AW-1:0] r_best_idx, n_best_idx;
    t_span         r_cur, n_cur;
    logic          r_out_valid, n_out_valid;
    t_span         r_out, n_out;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_span         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [SPAN_W-1:0] ram_rdata;
    t_span         w_rd;
    logic          w_out_free;
    logic          w_last_pass;
    logic          w_step;

    ism_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (MAX_INTERVALS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_rd        = t_span'(ram_rdata);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    // pass i is the final one when i + 1 >= n - 1
    assign w_last_pass = (CW'(r_i) + CW'(2)) >= r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_r         = r_r;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_j;
        n_first     = r_first;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = t_span'({i_interval_start, i_interval_end});
        ram_re      = 1'b0;
        ram_raddr   = r_j;
        w_step      = 1'b0;

        // scan data returns in the cycle after its read
        if (r_rd_vld) begin
            if (r_rd_idx == r_i) begin
                n_first    = w_rd;
                n_best     = w_rd;
                n_best_idx = r_i;
            end else if (r_best.lo > w_rd.lo) begin
                n_best     = w_rd;
                n_best_idx = r_rd_idx;
            end
        end

        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_count < CW'(MAX_INTERVALS)) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_batch_last) begin
                        n_i = '0;
                        n_j = '0;
                        n_r = '0;
                        n_state = (n_count <= CW'(1)) ? S_MRD : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ram_re   = 1'b1;
                ram_raddr = r_j;
                n_rd_vld = 1'b1;
                n_j      = r_j + AW'(1);
                if (CW'(r_j) == r_count - CW'(1)) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_SWAP1;
            end
            S_SWAP1, S_SWAP2: begin
                if (r_state == S_SWAP1 && r_best_idx != r_i) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_i;
                    ram_wdata = r_best;
                    n_state   = S_SWAP2;
                end else begin
                    if (r_state == S_SWAP2) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_best_idx;
                        ram_wdata = r_first;
                    end
                    if (w_last_pass) begin
                        n_r     = '0;
                        n_state = S_MRD;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_j     = r_i + AW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_MRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_r;
                n_state   = S_MCHK;
            end
            S_MCHK: begin
                if (r_r == '0) begin
                    n_cur  = w_rd;
                    w_step = 1'b1;
                end else if (spans_touch(r_cur, w_rd)) begin
                    n_cur  = span_union(r_cur, w_rd);
                    w_step = 1'b1;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_cur;
                    n_out_last  = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_cur       = w_rd;
                    w_step      = 1'b1;
                end
                if (w_step) begin
                    if (CW'(r_r) == r_count - CW'(1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_r     = r_r + AW'(1);
                        n_state = S_MRD;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_cur;
                    n_out_last  = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_r        <= n_r;
        r_rd_idx   <= n_rd_idx;
        r_first    <= n_first;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_cur      <= n_cur;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall     = (r_state != S_LOAD);
    assign o_out_valid    = r_out_valid;
    assign o_merged_start = r_out.lo;
    assign o_merged_end   = r_out.hi;
    assign o_run_last     = r_out_last;
    assign o_overflow     = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_INTERVALS))
        else $error("stored count exceeds capacity");

    a_best_is_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP1) |-> (r_best.lo <= r_first.lo && r_best_idx >= r_i))
        else $error("selected minimum not at or after pass index");

    a_flush_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && w_out_free) |=>
            (r_count == '0 && !r_ovf && r_out_valid && r_out_last && r_state == S_LOAD))
        else $error("batch flush did not emit final interval and clear");

endmodule
`default_nettype wire
